// ----- src/nea_pkg.sv -----
// Package with the types, constants and ring helpers of the neighbor exclusion arbiter.
package nea_pkg;

	localparam int NUM_SEATS  = 5;
	localparam int SEAT_IDX_W = $clog2(NUM_SEATS);
	localparam int SEAT_W     = 3;
	localparam int CNT_W      = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(10);

	typedef logic [SEAT_IDX_W-1:0] seat_idx_t;
	typedef logic [CNT_W-1:0]      count_t;

	typedef enum logic [1:0] {
		SEAT_THINKING = 2'd0,
		SEAT_HUNGRY   = 2'd1,
		SEAT_EATING   = 2'd2,
		SEAT_RESERVED = 2'd3
	} seat_state_t;

	typedef enum logic {
		OP_REQUEST = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_FIRST,
		SEQ_SECOND
	} seq_state_t;

	// One test step for the seat bank: an optional state write ahead of the test.
	typedef struct packed {
		logic        en;
		logic        pre_en;
		seat_idx_t   pre_seat;
		seat_state_t pre_state;
		seat_idx_t   test_seat;
	} bank_cmd_t;

	function automatic seat_idx_t left_of(seat_idx_t s);
		return (s == '0) ? SEAT_IDX_W'(NUM_SEATS - 1) : s - 1'b1;
	endfunction

	function automatic seat_idx_t right_of(seat_idx_t s);
		return (s == SEAT_IDX_W'(NUM_SEATS - 1)) ? '0 : s + 1'b1;
	endfunction

	function automatic logic seat_blocks(seat_state_t st);
		return (st == SEAT_EATING) || (st == SEAT_RESERVED);
	endfunction

endpackage

// ----- src/nea_if.sv -----
// Valid/ready channel interfaces for the arbiter's input items and results.
interface nea_in_if
	import nea_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [0:0]        operation;
	logic [SEAT_W-1:0] seat_id;

	modport source (output valid, output operation, output seat_id, input ready);
	modport sink   (input valid, input operation, input seat_id, output ready);
endinterface

interface nea_out_if
	import nea_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [SEAT_W-1:0] tested_seat;
	logic              granted;
	logic              last;

	modport source (output valid, output tested_seat, output granted, output last,
		input ready);
	modport sink   (input valid, input tested_seat, input granted, input last,
		output ready);
endinterface

// ----- src/neighbor_exclusion_arbiter_top.sv -----
// Top level of the neighbor exclusion arbiter: item register, test sequencer, result register.
//
// This block arbitrates among a ring of NUM_SEATS seats, where a seat
// may eat only while neither ring neighbor is eating or reserved. A request item
// (operation 0) makes the seat hungry and tests it, giving one result; a release item
// (operation 1) makes the seat thinking and then tests the left neighbor and the right
// neighbor, giving two results, the second with last set. A seat_id of NUM_SEATS or more
// is taken and dropped without any result. A request needs one test step and a release two,
// because the seat bank holds one test unit that evaluates one seat per cycle while the
// result register is not stalled, and the right-hand test must see the state left by the
// left-hand test. A new item is taken in the same cycle as the final test of the previous
// one. The result register holds one finished result; while it waits for its transfer the
// next test step stalls, and at most one further item is taken into the item register.
// Seat states and blocked counts are cleared directly by reset, so the block is ready
// as soon as reset is released. The starvation limit resets to 10 and is written through
// cfg_we and cfg_wdata; it should only be changed while no item is in flight.
module neighbor_exclusion_arbiter_top
	import nea_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	nea_in_if.sink           item,
	nea_out_if.source        result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	// Configuration register.
	count_t limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Item register and sequencer state.
	seq_state_t seq_state_q;
	seq_state_t seq_state_d;
	op_t        op_s1;
	seat_idx_t  seat_s1;

	// Result register.
	logic              res_valid_s2;
	logic [SEAT_W-1:0] res_seat_s2;
	logic              res_granted_s2;
	logic              res_last_s2;

	bank_cmd_t cmd;
	logic      step;
	logic      finish;
	logic      in_range;
	logic      accept;
	logic      step_last;
	logic      test_granted;

	// A test step runs whenever an item is loaded and the result register is free or
	// being emptied by a transfer in this cycle.
	assign step   = (seq_state_q != SEQ_IDLE) && (!res_valid_s2 || result.ready);
	assign finish = step && (((seq_state_q == SEQ_FIRST) && (op_s1 == OP_REQUEST)) ||
		(seq_state_q == SEQ_SECOND));

	assign item.ready = (seq_state_q == SEQ_IDLE) || finish;
	assign in_range   = 32'(item.seat_id) < NUM_SEATS;
	assign accept     = item.valid && item.ready && in_range;

	// Next state of the sequencer.
	always_comb begin
		seq_state_d = seq_state_q;
		unique case (seq_state_q)
			SEQ_IDLE: begin
				if (accept) begin
					seq_state_d = SEQ_FIRST;
				end
			end
			SEQ_FIRST: begin
				if (step) begin
					if (op_s1 == OP_REQUEST) begin
						seq_state_d = accept ? SEQ_FIRST : SEQ_IDLE;
					end else begin
						seq_state_d = SEQ_SECOND;
					end
				end
			end
			SEQ_SECOND: begin
				if (step) begin
					seq_state_d = accept ? SEQ_FIRST : SEQ_IDLE;
				end
			end
			default: begin
				seq_state_d = SEQ_IDLE;
			end
		endcase
	end

	// Sequencer outputs: the test command for the seat bank. The first step of an item
	// also writes the new state of the item's own seat ahead of the test.
	always_comb begin
		cmd.en        = step;
		cmd.pre_en    = 1'b0;
		cmd.pre_seat  = seat_s1;
		cmd.pre_state = SEAT_THINKING;
		cmd.test_seat = seat_s1;
		step_last     = 1'b1;
		unique case (seq_state_q)
			SEQ_IDLE: begin
				cmd.en = 1'b0;
			end
			SEQ_FIRST: begin
				cmd.pre_en = 1'b1;
				if (op_s1 == OP_REQUEST) begin
					cmd.pre_state = SEAT_HUNGRY;
					cmd.test_seat = seat_s1;
					step_last     = 1'b1;
				end else begin
					cmd.pre_state = SEAT_THINKING;
					cmd.test_seat = left_of(seat_s1);
					step_last     = 1'b0;
				end
			end
			SEQ_SECOND: begin
				cmd.test_seat = right_of(seat_s1);
				step_last     = 1'b1;
			end
			default: begin
				cmd.en = 1'b0;
			end
		endcase
	end

	nea_seat_bank u_bank (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.limit   (limit_q),
		.granted (test_granted)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_state_q <= SEQ_IDLE;
		end else begin
			seq_state_q <= seq_state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_t'(item.operation);
			seat_s1 <= SEAT_IDX_W'(item.seat_id);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (step) begin
			res_valid_s2 <= 1'b1;
		end else if (result.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_seat_s2    <= SEAT_W'(cmd.test_seat);
			res_granted_s2 <= test_granted;
			res_last_s2    <= step_last;
		end
	end

	assign result.valid       = res_valid_s2;
	assign result.tested_seat = res_seat_s2;
	assign result.granted     = res_granted_s2;
	assign result.last        = res_last_s2;

`ifndef SYNTHESIS
	// A result without last is the left-hand test of a release, so the right-hand test
	// must still be pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && !res_last_s2) |-> (seq_state_q == SEQ_SECOND))
		else $error("non-final result without a pending second test");

	// The second test only ever belongs to a release item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(seq_state_q == SEQ_SECOND) |-> (op_s1 == OP_RELEASE))
		else $error("second test step for a request item");

	// A test step always leaves a result in the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (res_valid_s2 && (res_last_s2 == $past(step_last))))
		else $error("test step did not load the result register");
`endif

endmodule

// ----- src/nea_seat_bank.sv -----
// Seat state and blocked count storage with the single-seat grant test.
module nea_seat_bank
	import nea_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  bank_cmd_t cmd,
	input  count_t    limit,
	output logic      granted
);

	seat_state_t state_q [NUM_SEATS];
	count_t      count_q [NUM_SEATS];
	seat_state_t view    [NUM_SEATS];
	seat_state_t state_d [NUM_SEATS];
	count_t      count_d [NUM_SEATS];
	seat_state_t cur;
	count_t      cnt_inc;
	logic        nb_free;

	always_comb begin
		view = state_q;
		if (cmd.pre_en) begin
			view[cmd.pre_seat] = cmd.pre_state;
		end
		cur     = view[cmd.test_seat];
		nb_free = !seat_blocks(view[left_of(cmd.test_seat)]) &&
			!seat_blocks(view[right_of(cmd.test_seat)]);
		granted = ((cur == SEAT_HUNGRY) || (cur == SEAT_RESERVED)) && nb_free;
		cnt_inc = (count_q[cmd.test_seat] == COUNT_MAX) ? COUNT_MAX
			: count_q[cmd.test_seat] + 1'b1;

		state_d = view;
		count_d = count_q;
		if (granted) begin
			state_d[cmd.test_seat] = SEAT_EATING;
			count_d[cmd.test_seat] = '0;
		end else if (cur == SEAT_HUNGRY) begin
			count_d[cmd.test_seat] = cnt_inc;
			if (cnt_inc >= limit) begin
				state_d[cmd.test_seat] = SEAT_RESERVED;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SEATS; i++) begin
				state_q[i] <= SEAT_THINKING;
				count_q[i] <= '0;
			end
		end else if (cmd.en) begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

endmodule
